FILE: sv/wwvs_pkg.sv
// Package for the wedge-weighted vertex sampler.
// Holds the table sizes, field widths, request and status codes and the sequencer states.
// No dependencies.
package wwvs_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int DEG_W        = 20;
  localparam int PROD_W       = 2 * DEG_W;
  localparam int WEIGHT_W     = 52;
  localparam int RAND_W       = 62;
  localparam int BIT_CNT_W    = $clog2(RAND_W);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_DIV,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_DONE
  } state_e;

endpackage

FILE: sv/wedge_weighted_vertex_sampler.sv
// Wedge-weighted vertex sampler: cumulative wedge-weight table with inverse-CDF sampling.
// Uses a bit-serial restoring modulo and an iterative binary search over an on-chip table.
// Depends on wwvs_pkg.
//
// Usage: one request channel (in_valid_i / in_stall_o) carries req_type_i, degree_i and
// random_value_i; one result channel (out_valid_o / out_stall_i) returns one result per
// request: vertex_index_o, total_weight_o and status_o.
// Requests are worked one at a time; in_stall_o is high from the transfer until the
// result has been loaded into the output register.
// Clear and unused codes go straight to loading the result; append runs the degree multiply,
// then the saturating add and the table write, then loads the result.
// A sample runs the one-bit-per-cycle modulo of the random value by the running total,
// then up to 13 search steps, each a table read and then a compare, as the table has a
// single registered read port, and then loads the result.
// A sample with zero total returns the zero-total status without the modulo or the search.
// Reset empties the table by clearing the vertex count and the running total; table
// entries are never cleared, as only entries below the count are read.
// While the receiver stalls, the result is held in the output register; the next request
// is taken meanwhile but its result waits until the register is free.
module wedge_weighted_vertex_sampler
  import wwvs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic [DEG_W-1:0]    degree_i,
  input  logic [RAND_W-1:0]   random_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IDX_W-1:0]    vertex_index_o,
  output logic [WEIGHT_W-1:0] total_weight_o,
  output logic [1:0]          status_o
);

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [WEIGHT_W-1:0]   total_q, total_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [RAND_W-1:0]     rand_q, rand_d;
  logic [WEIGHT_W-1:0]   rem_q, rem_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  status_e               stat_q, stat_d;

  logic                  out_valid_q, out_valid_d;
  logic [IDX_W-1:0]      out_idx_q, out_idx_d;
  logic [WEIGHT_W-1:0]   out_total_q, out_total_d;
  status_e               out_stat_q, out_stat_d;

  logic [WEIGHT_W-1:0]   mem [MAX_VERTICES];
  logic [WEIGHT_W-1:0]   rd_data_q;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [WEIGHT_W-1:0]   mem_wdata;

  logic                  in_xfer;
  logic [PROD_W-1:0]     deg_ext, degm1_ext;
  logic [WEIGHT_W:0]     sum;
  logic [WEIGHT_W:0]     trial;
  logic [WEIGHT_W:0]     trial_diff;
  logic [CNT_W-1:0]      mid_calc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // d*(d-1) is zero for d of 0 and 1, so the wrap of d-1 needs no special case
  assign deg_ext    = PROD_W'(degree_i);
  assign degm1_ext  = PROD_W'(degree_i - DEG_W'(1));
  assign sum        = {1'b0, total_q} + (WEIGHT_W + 1)'(prod_q >> 1);
  assign trial      = {rem_q, rand_q[RAND_W-1]};
  assign trial_diff = trial - {1'b0, total_q};
  assign mid_calc   = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    prod_d      = prod_q;
    rand_d      = rand_q;
    rem_d       = rem_q;
    bit_cnt_d   = bit_cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_total_d = out_total_q;
    out_stat_d  = out_stat_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = count_q[IDX_W-1:0];
    mem_wdata   = sum[WEIGHT_W-1:0];
    mem_raddr   = mid_calc[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          idx_d   = '0;
          stat_d  = ST_OK;
          state_d = S_DONE;
          unique case (req_type_i)
            REQ_CLEAR: begin
              count_d = '0;
              total_d = '0;
            end
            REQ_APPEND: begin
              prod_d = deg_ext * degm1_ext;
              if (count_q >= CNT_W'(MAX_VERTICES)) begin
                stat_d = ST_FULL;
              end else begin
                state_d = S_APPEND;
              end
            end
            REQ_SAMPLE: begin
              if (total_q == '0 || count_q == '0) begin
                stat_d = ST_ZERO;
              end else begin
                rand_d    = random_value_i;
                rem_d     = '0;
                bit_cnt_d = BIT_CNT_W'(RAND_W - 1);
                state_d   = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_APPEND: begin
        // saturate the running total at the top of the weight range
        if (sum[WEIGHT_W]) begin
          total_d = '1;
        end else begin
          total_d = sum[WEIGHT_W-1:0];
        end
        mem_we    = 1'b1;
        mem_wdata = total_d;
        idx_d     = count_q[IDX_W-1:0];
        count_d   = count_q + CNT_W'(1);
        state_d   = S_DONE;
      end
      S_DIV: begin
        // one restoring step: shift in the next bit, subtract the total if it fits
        if (trial >= {1'b0, total_q}) begin
          rem_d = trial_diff[WEIGHT_W-1:0];
        end else begin
          rem_d = trial[WEIGHT_W-1:0];
        end
        rand_d    = rand_q << 1;
        bit_cnt_d = bit_cnt_q - BIT_CNT_W'(1);
        if (bit_cnt_q == '0) begin
          lo_d    = '0;
          hi_d    = count_q;
          state_d = S_SEARCH_RD;
        end
      end
      S_SEARCH_RD: begin
        if (lo_q < hi_q) begin
          mem_re  = 1'b1;
          mid_d   = mid_calc;
          state_d = S_SEARCH_CMP;
        end else begin
          if (lo_q >= count_q) begin
            idx_d = IDX_W'(count_q - CNT_W'(1));
          end else begin
            idx_d = lo_q[IDX_W-1:0];
          end
          state_d = S_DONE;
        end
      end
      S_SEARCH_CMP: begin
        if (rd_data_q > rem_q) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + CNT_W'(1);
        end
        state_d = S_SEARCH_RD;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_idx_d   = idx_q;
          out_total_d = total_q;
          out_stat_d  = stat_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    rand_q      <= rand_d;
    rem_q       <= rem_d;
    bit_cnt_q   <= bit_cnt_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    idx_q       <= idx_d;
    stat_q      <= stat_d;
    out_idx_q   <= out_idx_d;
    out_total_q <= out_total_d;
    out_stat_q  <= out_stat_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = out_idx_q;
  assign total_weight_o = out_total_q;
  assign status_o       = out_stat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < total_q)
    else $error("modulo remainder not below total");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH_RD |-> hi_q <= count_q && lo_q <= hi_q)
    else $error("search bounds out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> vertex_index_o == '0)
    else $error("non-zero index on a flagged result");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the wedge-weighted vertex sampler: random and directed requests
// with a built-in predictor of the cumulative wedge-weight table and inverse-CDF search.
// Depends on wwvs_pkg and wedge_weighted_vertex_sampler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wwvs_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 1500;
  localparam int         STEADY_ITEMS = 300;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [WEIGHT_W-1:0] total;
    logic [1:0]          status;
  } sample_result_t;

  class sampler_scoreboard;
    logic [WEIGHT_W-1:0] cum_weight [MAX_VERTICES];
    int unsigned         n_vertices = 0;
    logic [WEIGHT_W-1:0] total      = '0;
    sample_result_t      awaited [$];
    int unsigned         errors    = 0;
    int unsigned         n_checked = 0;
    int unsigned         n_clears  = 0;
    int unsigned         n_appends = 0;
    int unsigned         n_dropped = 0;
    int unsigned         n_samples = 0;
    int unsigned         n_zero    = 0;

    // Work out the result of one accepted request and queue it.
    function void note_request(logic [1:0] req, logic [DEG_W-1:0] deg,
                               logic [RAND_W-1:0] rnd);
      sample_result_t      res;
      logic [PROD_W-1:0]   wedge;
      logic [WEIGHT_W:0]   sum;
      logic [63:0]         reduced;
      int unsigned         lo;
      int unsigned         hi;
      int unsigned         mid;
      res.index  = '0;
      res.status = ST_OK;
      case (req)
        REQ_CLEAR: begin
          n_vertices = 0;
          total      = '0;
          n_clears++;
        end
        REQ_APPEND: begin
          n_appends++;
          if (n_vertices >= MAX_VERTICES) begin
            res.status = ST_FULL;
            n_dropped++;
          end else begin
            wedge = (deg < 2) ? '0
                  : (PROD_W'(deg) * PROD_W'(deg - 1'b1)) >> 1;
            sum   = {1'b0, total} + (WEIGHT_W + 1)'(wedge);
            // saturate at the top of the weight range
            total = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
            cum_weight[n_vertices] = total;
            res.index = n_vertices[IDX_W-1:0];
            n_vertices++;
          end
        end
        REQ_SAMPLE: begin
          n_samples++;
          if (total == '0 || n_vertices == 0) begin
            res.status = ST_ZERO;
            n_zero++;
          end else begin
            reduced = {2'b00, rnd} % {12'b0, total};
            lo = 0;
            hi = n_vertices;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (cum_weight[mid] > reduced[WEIGHT_W-1:0]) hi = mid;
              else lo = mid + 1;
            end
            if (lo >= n_vertices) lo = n_vertices - 1;
            res.index = lo[IDX_W-1:0];
          end
        end
        default: ;
      endcase
      res.total = total;
      awaited.push_back(res);
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic [WEIGHT_W-1:0] tw,
                               logic [1:0] st);
      sample_result_t exp_res;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result index %0d total %0d status %0d",
                 $time, idx, tw, st);
        return;
      end
      exp_res = awaited.pop_front();
      n_checked++;
      if (idx !== exp_res.index) begin
        errors++;
        $display("%0t: vertex_index expected %0d actual %0d", $time, exp_res.index, idx);
      end
      if (tw !== exp_res.total) begin
        errors++;
        $display("%0t: total_weight expected %0d actual %0d", $time, exp_res.total, tw);
      end
      if (st !== exp_res.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, st);
      end
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [1:0]          req_type_i     = REQ_CLEAR;
  logic [DEG_W-1:0]    degree_i       = '0;
  logic [RAND_W-1:0]   random_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [IDX_W-1:0]    vertex_index_o;
  logic [WEIGHT_W-1:0] total_weight_o;
  logic [1:0]          status_o;

  logic                steady = 1'b0;
  int unsigned         n_sent = 0;
  sampler_scoreboard   sb;

  wedge_weighted_vertex_sampler dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .degree_i,
    .random_value_i,
    .out_valid_o,
    .out_stall_i,
    .vertex_index_o,
    .total_weight_o,
    .status_o
  );

  always #5 clk_i = ~clk_i;

  // Result side: check each transfer, then stall at random outside the steady phase.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(vertex_index_o, total_weight_o, status_o);
    out_stall_i <= !steady && ($urandom_range(99) < 36);
  end

  function automatic logic [DEG_W-1:0] random_degree();
    case ($urandom_range(7))
      0:       return DEG_W'($urandom_range(1));
      1:       return '1;
      2, 3:    return DEG_W'($urandom_range(2, 40));
      default: return DEG_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAND_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return RAND_W'($urandom_range(1000));
      default: return RAND_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic issue_request(input logic [1:0] req, input logic [DEG_W-1:0] deg,
                               input logic [RAND_W-1:0] rnd);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 36) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    degree_i       <= deg;
    random_value_i <= rnd;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, deg, rnd);
    n_sent++;
  endtask

  initial begin
    int unsigned base;
    int unsigned n_app;
    int unsigned n_smp;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, unused code, zero-weight degrees, extremes of the fields.
    issue_request(REQ_SAMPLE, '0, '1);
    issue_request(REQ_UNUSED, '1, '1);
    issue_request(REQ_APPEND, '0, '0);
    issue_request(REQ_APPEND, 20'd1, '0);
    issue_request(REQ_SAMPLE, '0, 62'd12345);
    issue_request(REQ_APPEND, 20'd2, '0);
    issue_request(REQ_SAMPLE, '0, '0);
    issue_request(REQ_SAMPLE, '0, '1);
    issue_request(REQ_APPEND, '1, '0);
    issue_request(REQ_APPEND, 20'd0, '1);
    issue_request(REQ_APPEND, '1, '0);
    issue_request(REQ_APPEND, 20'd3, '0);
    issue_request(REQ_SAMPLE, '1, '1);
    issue_request(REQ_SAMPLE, '0, '0);
    issue_request(REQ_SAMPLE, '0, 62'd1);
    issue_request(REQ_SAMPLE, '0, {1'b0, {(RAND_W-1){1'b1}}});
    issue_request(REQ_UNUSED, '0, '0);
    issue_request(REQ_CLEAR, '1, '1);
    issue_request(REQ_SAMPLE, '0, '1);
    issue_request(REQ_APPEND, 20'd5, '0);
    issue_request(REQ_SAMPLE, '0, '1);

    // Fill the table to capacity, push past it, then sample the full table.
    issue_request(REQ_CLEAR, '0, '0);
    repeat (MAX_VERTICES) issue_request(REQ_APPEND, random_degree(), random_word());
    repeat (3) issue_request(REQ_APPEND, random_degree(), random_word());
    issue_request(REQ_SAMPLE, '0, '0);
    issue_request(REQ_SAMPLE, '0, '1);
    repeat (20) issue_request(REQ_SAMPLE, random_degree(), random_word());

    // Random: mostly clear/append/sample runs, the rest noise; no idling at first.
    steady <= 1'b1;
    base = n_sent;
    while (n_sent - base < RANDOM_ITEMS) begin
      if (steady && n_sent - base >= STEADY_ITEMS) steady <= 1'b0;
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(99) < 70)
          issue_request(REQ_CLEAR, random_degree(), random_word());
        n_app = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
              : $urandom_range(1, 24);
        n_smp = $urandom_range(1, 20);
        repeat (n_app) issue_request(REQ_APPEND, random_degree(), random_word());
        repeat (n_smp) begin
          if ($urandom_range(9) == 0)
            issue_request(REQ_APPEND, random_degree(), random_word());
          issue_request(REQ_SAMPLE, random_degree(), random_word());
        end
      end else begin
        repeat ($urandom_range(1, 6))
          issue_request(2'($urandom_range(3)), random_degree(), random_word());
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow one more request's worth of cycles.
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("Checked %0d results from %0d requests: %0d clears, %0d appends (%0d dropped),",
             sb.n_checked, n_sent, sb.n_clears, sb.n_appends, sb.n_dropped);
    $display("%0d samples (%0d on a zero total), %0d field mismatches",
             sb.n_samples, sb.n_zero, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #15_000_000;
    $display("Timeout at %0t with %0d results outstanding", $time, sb.awaited.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
